>>> sv/acpi_embedded_controller_port_assert.svh
`ifndef ACPI_EMBEDDED_CONTROLLER_PORT_ASSERT_SVH
`define ACPI_EMBEDDED_CONTROLLER_PORT_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define AECP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("aecp assertion failed");

// next-cycle implication, sampled on aclk, off during reset
`define AECP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("aecp assertion failed");

`endif

>>> sv/aecp_pkg.sv
`timescale 1ns / 1ps

package aecp_pkg;

    localparam int EVENT_DEPTH = 8;
    localparam int EV_CNT_W    = $clog2(EVENT_DEPTH + 1);
    localparam int EV_IDX_W    = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
    localparam int STORE_DEPTH = 256;
    localparam int STORE_AW    = 8;

    localparam logic [7:0] CMD_READ      = 8'h80;
    localparam logic [7:0] CMD_WRITE     = 8'h81;
    localparam logic [7:0] CMD_BURST_ON  = 8'h82;
    localparam logic [7:0] CMD_BURST_OFF = 8'h83;
    localparam logic [7:0] CMD_QUERY     = 8'h84;
    localparam logic [7:0] BURST_ANSWER  = 8'h90;

    localparam logic [7:0] ST_OBF   = 8'h01;
    localparam logic [7:0] ST_BURST = 8'h10;
    localparam logic [7:0] ST_SCI   = 8'h20;

    typedef enum logic [2:0] {
        OP_STATUS = 3'd0,
        OP_CMD    = 3'd1,
        OP_DWRITE = 3'd2,
        OP_DREAD  = 3'd3,
        OP_RAISE  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        FLT_OK    = 2'd0,
        FLT_CMD   = 2'd1,
        FLT_DATA  = 2'd2,
        FLT_QFULL = 2'd3
    } fault_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic [7:0] event_number;
    } in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       output_full;
        logic       burst_active;
        logic       event_pending;
        fault_t     fault;
    } out_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] ev;
    } evq_cmd_t;

    typedef struct packed {
        logic nonempty;
        logic single;
        logic full;
    } evq_stat_t;

endpackage

>>> sv/aecp_ram.sv
`timescale 1ns / 1ps

module aecp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                    aclk,
    input  logic                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/aecp_evq.sv
`timescale 1ns / 1ps

module aecp_evq
    import aecp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  evq_cmd_t   cmd,
    output evq_stat_t  stat,
    output logic [7:0] rdata
);

    `include "acpi_embedded_controller_port_assert.svh"

    logic [EV_IDX_W-1:0] head_reg, head_next;
    logic [EV_CNT_W-1:0] count_reg, count_next;
    logic [EV_CNT_W:0]   tail_sum;
    logic [EV_CNT_W:0]   tail_wrap;
    logic [EV_IDX_W-1:0] tail_idx;

    assign tail_sum  = (EV_CNT_W + 1)'(head_reg) + (EV_CNT_W + 1)'(count_reg);
    assign tail_wrap = (tail_sum >= (EV_CNT_W + 1)'(EVENT_DEPTH))
                     ? tail_sum - (EV_CNT_W + 1)'(EVENT_DEPTH) : tail_sum;
    assign tail_idx  = tail_wrap[EV_IDX_W-1:0];

    assign stat.nonempty = (count_reg != '0);
    assign stat.single   = (count_reg == EV_CNT_W'(1));
    assign stat.full     = (count_reg == EV_CNT_W'(EVENT_DEPTH));

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.pop) begin
            head_next  = (head_reg == EV_IDX_W'(EVENT_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end else if (cmd.push) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    aecp_ram #(
        .WIDTH (8),
        .DEPTH (EVENT_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.push),
        .waddr (tail_idx),
        .wdata (cmd.ev),
        .raddr (head_reg),
        .rdata (rdata)
    );

    `AECP_ASSERT_NOW(a_no_push_full, cmd.push, !stat.full)
    `AECP_ASSERT_NOW(a_no_pop_empty, cmd.pop, stat.nonempty)
    `AECP_ASSERT_NEXT(a_pop_drops_one, cmd.pop && !cmd.push,
                      count_reg == $past(count_reg) - 1'b1)

endmodule

>>> sv/acpi_embedded_controller_port.sv
`timescale 1ns / 1ps

// channel   ports                      payload
// request   s_valid s_ready s_data     in_t  {op, data_byte, event_number}
// result    m_valid m_ready m_data     out_t {read_data, output_full, burst_active,
//                                             event_pending, fault}
//
// One request at a time, one result per request.
// Most requests are answered from the idle state; a register read (data write in
// the read-address phase) and a query with a pending event go through a wait
// state, set by the registered read of the register store RAM and of the event RAM.
// Register store entries read as zero until written (one valid flop per byte);
// no clearing pass after reset.
// A stalled result holds the request side only when the output register is full.

module acpi_embedded_controller_port
    import aecp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    `include "acpi_embedded_controller_port_assert.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_QUERY
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RD_ADDR,
        PH_WR_ADDR,
        PH_WR_DATA
    } phase_t;

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [STORE_AW-1:0]    offset_reg, offset_next;
    logic [7:0]             obyte_reg, obyte_next;
    logic                   obf_reg, obf_next;
    logic                   burst_reg, burst_next;
    logic [STORE_DEPTH-1:0] vld_reg, vld_next;
    logic                   load_vld_reg, load_vld_next;
    logic                   m_valid_reg, m_valid_next;
    out_t                   m_data_reg, m_data_next;

    logic       take;
    logic       store_we;
    logic [7:0] store_rdata;
    logic [7:0] rd;
    fault_t     flt;
    logic       pending;
    evq_cmd_t   evq_cmd;
    evq_stat_t  evq_stat;
    logic [7:0] evq_rdata;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign take    = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        offset_next   = offset_reg;
        obyte_next    = obyte_reg;
        obf_next      = obf_reg;
        burst_next    = burst_reg;
        vld_next      = vld_reg;
        load_vld_next = load_vld_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        store_we      = 1'b0;
        evq_cmd       = '0;
        evq_cmd.ev    = s_data.event_number;
        rd            = 8'h00;
        flt           = FLT_OK;
        pending       = evq_stat.nonempty;

        unique case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    unique case (s_data.op)
                        OP_STATUS: begin
                            if (obf_reg) rd = rd | ST_OBF;
                            if (burst_reg) rd = rd | ST_BURST;
                            if (evq_stat.nonempty) rd = rd | ST_SCI;
                        end
                        OP_CMD: begin
                            obf_next   = 1'b0;
                            phase_next = PH_IDLE;
                            case (s_data.data_byte)
                                CMD_READ:      phase_next = PH_RD_ADDR;
                                CMD_WRITE:     phase_next = PH_WR_ADDR;
                                CMD_BURST_ON: begin
                                    burst_next = 1'b1;
                                    obyte_next = BURST_ANSWER;
                                    obf_next   = 1'b1;
                                end
                                CMD_BURST_OFF: burst_next = 1'b0;
                                CMD_QUERY: begin
                                    if (evq_stat.nonempty) begin
                                        evq_cmd.pop = 1'b1;
                                        state_next  = ST_QUERY;
                                    end else begin
                                        obyte_next = 8'h00;
                                        obf_next   = 1'b1;
                                    end
                                end
                                default:       flt = FLT_CMD;
                            endcase
                        end
                        OP_DWRITE: begin
                            unique case (phase_reg)
                                PH_RD_ADDR: begin
                                    offset_next   = s_data.data_byte;
                                    load_vld_next = vld_reg[s_data.data_byte];
                                    phase_next    = PH_IDLE;
                                    state_next    = ST_LOAD;
                                end
                                PH_WR_ADDR: begin
                                    offset_next = s_data.data_byte;
                                    phase_next  = PH_WR_DATA;
                                end
                                PH_WR_DATA: begin
                                    store_we             = 1'b1;
                                    vld_next[offset_reg] = 1'b1;
                                    phase_next           = PH_IDLE;
                                end
                                PH_IDLE:    flt = FLT_DATA;
                            endcase
                        end
                        OP_DREAD: begin
                            rd = obyte_reg;
                            if (obf_reg) obf_next = 1'b0;
                            else flt = FLT_DATA;
                        end
                        OP_RAISE: begin
                            if (s_data.event_number != 8'h00) begin
                                if (evq_stat.full) flt = FLT_QFULL;
                                else evq_cmd.push = 1'b1;
                            end
                        end
                        default: ;
                    endcase

                    if (evq_cmd.push) pending = 1'b1;
                    else if (evq_cmd.pop) pending = !evq_stat.single;

                    if (state_next == ST_IDLE) begin
                        m_valid_next              = 1'b1;
                        m_data_next.read_data     = rd;
                        m_data_next.output_full   = obf_next;
                        m_data_next.burst_active  = burst_next;
                        m_data_next.event_pending = pending;
                        m_data_next.fault         = flt;
                    end
                end
            end
            ST_LOAD, ST_QUERY: begin
                obyte_next = (state_reg == ST_LOAD)
                           ? (load_vld_reg ? store_rdata : 8'h00) : evq_rdata;
                obf_next                  = 1'b1;
                state_next                = ST_IDLE;
                m_valid_next              = 1'b1;
                m_data_next.read_data     = 8'h00;
                m_data_next.output_full   = 1'b1;
                m_data_next.burst_active  = burst_reg;
                m_data_next.event_pending = evq_stat.nonempty;
                m_data_next.fault         = FLT_OK;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_IDLE;
            offset_reg   <= '0;
            obyte_reg    <= '0;
            obf_reg      <= 1'b0;
            burst_reg    <= 1'b0;
            vld_reg      <= '0;
            load_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            offset_reg   <= offset_next;
            obyte_reg    <= obyte_next;
            obf_reg      <= obf_next;
            burst_reg    <= burst_next;
            vld_reg      <= vld_next;
            load_vld_reg <= load_vld_next;
            m_valid_reg  <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    aecp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (offset_reg),
        .wdata (s_data.data_byte),
        .raddr (s_data.data_byte),
        .rdata (store_rdata)
    );

    aecp_evq u_evq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (evq_cmd),
        .stat    (evq_stat),
        .rdata   (evq_rdata)
    );

    `AECP_ASSERT_NOW(a_wait_slot_free, state_reg != ST_IDLE, !m_valid_reg)
    `AECP_ASSERT_NEXT(a_dread_clears_obf, take && s_data.op == OP_DREAD && obf_reg, !obf_reg)
    `AECP_ASSERT_NEXT(a_wait_returns_idle, state_reg != ST_IDLE,
                      state_reg == ST_IDLE && m_valid_reg && obf_reg)

endmodule
